>>> hdl/cpcbm_pkg.sv
// Shared types and constants for the charge port cutoff and blink monitor.
package cpcbm_pkg;

	// Request codes carried in req_type
	localparam logic [1:0] REQ_SAMPLE = 2'd0;
	localparam logic [1:0] REQ_BLINK  = 2'd1;
	localparam logic [1:0] REQ_PRESS  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_LOW_MA  = 2'd0;
	localparam logic [1:0] CFG_CUTOFF  = 2'd1;
	localparam logic [1:0] CFG_BLINK_DIV = 2'd2;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam int unsigned ADC_W   = 10;
	localparam int unsigned MA_W    = 11;
	localparam int unsigned LOW_W   = 16;
	localparam int unsigned BLINK_W = 8;
	localparam int unsigned PAUSE_W = 2;
	localparam int unsigned PRESC_W = 10;
	localparam int unsigned PROD_W  = 14;

	// Number of ports that have ADC and output fields
	localparam int unsigned PORT_FIELDS = 3;

	localparam logic [MA_W-1:0]    LOW_MA_RST    = 11'd50;
	localparam logic [LOW_W-1:0]   CUTOFF_RST    = 16'd48;
	localparam logic [PRESC_W-1:0] BLINK_DIV_RST = 10'd400;
	localparam logic [PROD_W-1:0]  MA_PER_BLINK  = 14'd100;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [ADC_W-1:0] adc_port0;
		logic [ADC_W-1:0] adc_port1;
		logic [ADC_W-1:0] adc_port2;
		logic [1:0]       press_port;
	} in_item_t;

	typedef struct packed {
		logic power_on_port0;
		logic power_on_port1;
		logic power_on_port2;
		logic lamp_port0;
		logic lamp_port1;
		logic lamp_port2;
	} out_item_t;

	// Per-lane command for one accepted transaction
	typedef struct packed {
		logic sample;
		logic step;
		logic press;
	} lane_ctl_t;

	typedef struct packed {
		logic [MA_W-1:0]  low_ma;
		logic [LOW_W-1:0] cutoff;
	} lane_cfg_t;

	typedef struct packed {
		logic power_on;
		logic lamp;
	} lane_stat_t;

endpackage

>>> hdl/charge_port_cutoff_blink_monitor_unit.sv
// Top level of the charge port cutoff and blink monitor.
// Each accepted transaction (sample tick, blink tick or switch press) updates all
// port lanes in the cycle it is accepted, and its result enters a two-entry output
// queue; when the queue was empty, the result is at its head on the next cycle. A new
// transaction can be accepted every cycle while the queue has room. One lane per port
// does the scaling, cutoff and blink sequencing; the shared blink prescaler lives
// here. Configuration writes take effect at the next edge.
module charge_port_cutoff_blink_monitor_unit #(
	parameter int unsigned NUM_PORTS = 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  cpcbm_pkg::in_item_t                  in_item,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output cpcbm_pkg::out_item_t                 out_item,
	input  logic                                 cfg_we,
	input  logic [cpcbm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cpcbm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [cpcbm_pkg::MA_W-1:0]    low_ma_q;
	logic [cpcbm_pkg::LOW_W-1:0]   cutoff_q;
	logic [cpcbm_pkg::PRESC_W-1:0] blink_div_q;
	logic [cpcbm_pkg::PRESC_W-1:0] presc_q, presc_inc;
	logic                          accept, is_sample, is_blink, is_press, step;
	cpcbm_pkg::lane_cfg_t          lane_cfg;
	cpcbm_pkg::lane_stat_t         stat [NUM_PORTS];
	logic                          space;

	assign in_ready = space;
	assign accept   = in_valid && in_ready;

	always_comb begin
		is_sample = 1'b0;
		is_blink  = 1'b0;
		is_press  = 1'b0;
		case (in_item.req_type)
			cpcbm_pkg::REQ_SAMPLE: is_sample = accept;
			cpcbm_pkg::REQ_BLINK:  is_blink  = accept;
			cpcbm_pkg::REQ_PRESS:  is_press  = accept;
			default:               is_sample = 1'b0;
		endcase
	end

	assign presc_inc = presc_q + 1'b1;
	assign step      = is_blink && (presc_inc == blink_div_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presc_q <= '0;
		end else if (is_blink) begin
			presc_q <= step ? '0 : presc_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_ma_q    <= cpcbm_pkg::LOW_MA_RST;
			cutoff_q    <= cpcbm_pkg::CUTOFF_RST;
			blink_div_q <= cpcbm_pkg::BLINK_DIV_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				cpcbm_pkg::CFG_LOW_MA:    low_ma_q    <= cfg_data[cpcbm_pkg::MA_W-1:0];
				cpcbm_pkg::CFG_CUTOFF:    cutoff_q    <= cfg_data[cpcbm_pkg::LOW_W-1:0];
				cpcbm_pkg::CFG_BLINK_DIV: blink_div_q <= cfg_data[cpcbm_pkg::PRESC_W-1:0];
				default:                  low_ma_q    <= low_ma_q;
			endcase
		end
	end

	assign lane_cfg.low_ma = low_ma_q;
	assign lane_cfg.cutoff = cutoff_q;

	for (genvar p = 0; p < NUM_PORTS; p++) begin : g_lane
		logic [cpcbm_pkg::ADC_W-1:0] adc;
		cpcbm_pkg::lane_ctl_t        ctl;

		if (p == 0) begin : g_adc0
			assign adc = in_item.adc_port0;
		end else if (p == 1) begin : g_adc1
			assign adc = in_item.adc_port1;
		end else if (p == 2) begin : g_adc2
			assign adc = in_item.adc_port2;
		end else begin : g_adcz
			assign adc = '0;
		end

		assign ctl.sample = is_sample;
		assign ctl.step   = step;
		assign ctl.press  = is_press && (32'(in_item.press_port) == p);

		cpcbm_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.cfg       (lane_cfg),
			.adc       (adc),
			.stat_next (stat[p])
		);
	end

	cpcbm_merge #(
		.NUM_PORTS (NUM_PORTS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.stat      (stat),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

>>> hdl/cpcbm_lane.sv
// One port lane: current scaling, low-current cutoff and blink-code sequencer.
module cpcbm_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cpcbm_pkg::lane_ctl_t          ctl,
	input  cpcbm_pkg::lane_cfg_t          cfg,
	input  logic [cpcbm_pkg::ADC_W-1:0]   adc,
	output cpcbm_pkg::lane_stat_t         stat_next
);

	logic [cpcbm_pkg::MA_W-1:0]    ma_q, ma_n;
	logic [cpcbm_pkg::LOW_W-1:0]   lc_q, lc_n;
	logic [cpcbm_pkg::BLINK_W-1:0] bc_q, bc_n;
	logic [cpcbm_pkg::PAUSE_W-1:0] pc_q, pc_n;
	logic                          en_q, en_n;
	logic                          lamp_q, lamp_n;
	logic [cpcbm_pkg::MA_W-1:0]    ma_scaled;
	logic [cpcbm_pkg::PROD_W-1:0]  blink_ma;

	// 6*adc/4 == adc + adc/2
	assign ma_scaled = cpcbm_pkg::MA_W'(adc) + cpcbm_pkg::MA_W'(adc >> 1);

	always_comb begin
		ma_n   = ma_q;
		lc_n   = lc_q;
		bc_n   = bc_q;
		pc_n   = pc_q;
		en_n   = en_q;
		lamp_n = lamp_q;
		blink_ma = '0;
		if (ctl.sample) begin
			ma_n = ma_scaled;
			if (ma_scaled < cfg.low_ma) begin
				if (lc_q != '1) begin
					lc_n = lc_q + 1'b1;
				end
				if (lc_n >= cfg.cutoff) begin
					en_n = 1'b0;
				end
			end else begin
				lc_n = '0;
			end
		end
		if (ctl.step) begin
			bc_n = bc_q + 1'b1;
			blink_ma = cpcbm_pkg::PROD_W'(bc_n[cpcbm_pkg::BLINK_W-1:1]) * cpcbm_pkg::MA_PER_BLINK;
			if (bc_n[0]) begin
				lamp_n = 1'b0;
			end else if (blink_ma <= cpcbm_pkg::PROD_W'(ma_q)) begin
				lamp_n = 1'b1;
				pc_n   = '0;
			end else begin
				if (pc_q != '1) begin
					pc_n = pc_q + 1'b1;
				end
				lamp_n = 1'b0;
				// pause of two steps ends the code
				if (pc_n[1]) begin
					bc_n = '0;
				end
			end
		end
		if (ctl.press) begin
			en_n   = 1'b1;
			lamp_n = 1'b1;
			lc_n   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ma_q   <= '0;
			lc_q   <= '0;
			bc_q   <= '0;
			pc_q   <= '0;
			en_q   <= 1'b1;
			lamp_q <= 1'b1;
		end else begin
			ma_q   <= ma_n;
			lc_q   <= lc_n;
			bc_q   <= bc_n;
			pc_q   <= pc_n;
			en_q   <= en_n;
			lamp_q <= lamp_n;
		end
	end

	assign stat_next.power_on = en_n;
	assign stat_next.lamp     = lamp_n;

endmodule

>>> hdl/cpcbm_merge.sv
// Merges lane status into result transactions and queues them two deep.
module cpcbm_merge #(
	parameter int unsigned NUM_PORTS = 3
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  cpcbm_pkg::lane_stat_t  stat [NUM_PORTS],
	output logic                   space,
	output logic                   out_valid,
	input  logic                   out_ready,
	output cpcbm_pkg::out_item_t   out_item
);

	logic [cpcbm_pkg::PORT_FIELDS-1:0] pw_pad, lamp_pad;
	cpcbm_pkg::out_item_t              new_item;
	cpcbm_pkg::out_item_t              q0_q, q1_q;
	logic [1:0]                        count_q;
	logic                              pop;

	for (genvar j = 0; j < cpcbm_pkg::PORT_FIELDS; j++) begin : g_pad
		if (j < NUM_PORTS) begin : g_live
			assign pw_pad[j]   = stat[j].power_on;
			assign lamp_pad[j] = stat[j].lamp;
		end else begin : g_none
			assign pw_pad[j]   = 1'b0;
			assign lamp_pad[j] = 1'b0;
		end
	end

	always_comb begin
		new_item.power_on_port0 = pw_pad[0];
		new_item.power_on_port1 = pw_pad[1];
		new_item.power_on_port2 = pw_pad[2];
		new_item.lamp_port0     = lamp_pad[0];
		new_item.lamp_port1     = lamp_pad[1];
		new_item.lamp_port2     = lamp_pad[2];
	end

	assign out_valid = count_q != 2'd0;
	assign space     = count_q != 2'd2;
	assign pop       = out_valid && out_ready;
	assign out_item  = q0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (count_q == 2'd0) begin
					q0_q <= new_item;
				end else begin
					q1_q <= new_item;
				end
			end
			2'b01: begin
				q0_q <= q1_q;
			end
			2'b11: begin
				if (count_q == 2'd1) begin
					q0_q <= new_item;
				end else begin
					q0_q <= q1_q;
					q1_q <= new_item;
				end
			end
			default: begin
				q0_q <= q0_q;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result queue count out of range");

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != 2'd2)
		else $error("push into full result queue");

	a_empty_push: assert property (@(posedge clk) disable iff (!arst_n)
		(push && count_q == 2'd0) |=> (out_valid && out_item == $past(new_item)))
		else $error("pushed result not at queue head");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push && count_q == 2'd1) |=> !out_valid)
		else $error("queue not empty after last pop");
`endif

endmodule

>>> verif/cpcbm_checker.sv
// Checker for the charge port monitor: tracks port state, predicts each status and compares.
`timescale 1ns / 1ps

module cpcbm_checker
	import cpcbm_pkg::*;
#(
	parameter int unsigned NUM_PORTS = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_item_t              in_item,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_item_t             out_item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int unsigned           mismatch_count,
	output int unsigned           results_pending
);

	logic [MA_W-1:0]    low_ma_r;
	logic [LOW_W-1:0]   cutoff_r;
	logic [PRESC_W-1:0] divide_r;

	logic [MA_W-1:0]    port_ma   [NUM_PORTS];
	logic [LOW_W-1:0]   low_run   [NUM_PORTS];
	logic [BLINK_W-1:0] blink_pos [NUM_PORTS];
	logic [PAUSE_W-1:0] pause_run [NUM_PORTS];
	logic               powered   [NUM_PORTS];
	logic               lamp_on   [NUM_PORTS];
	logic [PRESC_W-1:0] presc;

	out_item_t   status_q[$];
	int unsigned errs;
	int unsigned seen;

	function automatic void clear_ports();
		low_ma_r = LOW_MA_RST;
		cutoff_r = CUTOFF_RST;
		divide_r = BLINK_DIV_RST;
		presc = '0;
		for (int p = 0; p < NUM_PORTS; p++) begin
			port_ma[p] = '0;
			low_run[p] = '0;
			blink_pos[p] = '0;
			pause_run[p] = '0;
			powered[p] = 1'b1;
			lamp_on[p] = 1'b1;
		end
	endfunction

	// One divided blink tick: advance every port's LED pattern
	function automatic void blink_advance();
		for (int p = 0; p < NUM_PORTS; p++) begin
			blink_pos[p] = blink_pos[p] + 1'b1;
			if (blink_pos[p][0]) begin
				lamp_on[p] = 1'b0;
			end else if (int'(MA_PER_BLINK) * int'(blink_pos[p] >> 1) <= int'(port_ma[p])) begin
				lamp_on[p] = 1'b1;
				pause_run[p] = '0;
			end else begin
				if (pause_run[p] != '1)
					pause_run[p] = pause_run[p] + 1'b1;
				lamp_on[p] = 1'b0;
				if (pause_run[p] >= 2)
					blink_pos[p] = '0;
			end
		end
	endfunction

	function automatic out_item_t predict_status(input in_item_t it);
		logic [ADC_W-1:0] adc_of [PORT_FIELDS];
		logic [ADC_W-1:0] adc;
		logic [2:0]       pw;
		logic [2:0]       lp;
		out_item_t        st;
		adc_of[0] = it.adc_port0;
		adc_of[1] = it.adc_port1;
		adc_of[2] = it.adc_port2;
		case (it.req_type)
		REQ_SAMPLE: begin
			for (int p = 0; p < NUM_PORTS; p++) begin
				adc = (p < PORT_FIELDS) ? adc_of[p] : '0;
				port_ma[p] = MA_W'((int'(adc) * 6) / 4);
				if (port_ma[p] < low_ma_r) begin
					if (low_run[p] != '1)
						low_run[p] = low_run[p] + 1'b1;
					if (low_run[p] >= cutoff_r)
						powered[p] = 1'b0;
				end else begin
					low_run[p] = '0;
				end
			end
		end
		REQ_BLINK: begin
			presc = presc + 1'b1;
			if (presc == divide_r) begin
				presc = '0;
				blink_advance();
			end
		end
		REQ_PRESS: begin
			if (int'(it.press_port) < NUM_PORTS) begin
				powered[it.press_port] = 1'b1;
				lamp_on[it.press_port] = 1'b1;
				low_run[it.press_port] = '0;
			end
		end
		default: ;
		endcase
		for (int j = 0; j < PORT_FIELDS; j++) begin
			pw[j] = (j < NUM_PORTS) ? powered[j] : 1'b0;
			lp[j] = (j < NUM_PORTS) ? lamp_on[j] : 1'b0;
		end
		st.power_on_port0 = pw[0];
		st.power_on_port1 = pw[1];
		st.power_on_port2 = pw[2];
		st.lamp_port0 = lp[0];
		st.lamp_port1 = lp[1];
		st.lamp_port2 = lp[2];
		return st;
	endfunction

	function automatic void check_status(input out_item_t want, input out_item_t got);
		int unsigned bad;
		bad = 0;
		if (got.power_on_port0 !== want.power_on_port0) bad++;
		if (got.power_on_port1 !== want.power_on_port1) bad++;
		if (got.power_on_port2 !== want.power_on_port2) bad++;
		if (got.lamp_port0 !== want.lamp_port0) bad++;
		if (got.lamp_port1 !== want.lamp_port1) bad++;
		if (got.lamp_port2 !== want.lamp_port2) bad++;
		if (bad != 0) begin
			errs++;
			if (errs <= 10)
				$display("status %0d mismatch at %0t: expected power=%b%b%b lamp=%b%b%b, got power=%b%b%b lamp=%b%b%b",
					seen, $time,
					want.power_on_port0, want.power_on_port1, want.power_on_port2,
					want.lamp_port0, want.lamp_port1, want.lamp_port2,
					got.power_on_port0, got.power_on_port1, got.power_on_port2,
					got.lamp_port0, got.lamp_port1, got.lamp_port2);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_ports();
			status_q.delete();
			errs = 0;
			seen = 0;
			mismatch_count <= 0;
			results_pending <= 0;
		end else begin
			if (in_valid && in_ready)
				status_q.push_back(predict_status(in_item));
			if (out_valid && out_ready) begin
				seen++;
				if (status_q.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("status %0d at %0t arrived with none outstanding: power=%b%b%b lamp=%b%b%b",
							seen, $time,
							out_item.power_on_port0, out_item.power_on_port1, out_item.power_on_port2,
							out_item.lamp_port0, out_item.lamp_port1, out_item.lamp_port2);
				end else begin
					check_status(status_q.pop_front(), out_item);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
				CFG_LOW_MA:    low_ma_r = cfg_data[MA_W-1:0];
				CFG_CUTOFF:    cutoff_r = cfg_data[LOW_W-1:0];
				CFG_BLINK_DIV: divide_r = cfg_data[PRESC_W-1:0];
				default: ;
				endcase
			end
			mismatch_count <= errs;
			results_pending <= status_q.size();
		end
	end

endmodule

>>> verif/tb_charge_port_cutoff_blink_monitor_unit.sv
// Testbench top for the charge port monitor: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_charge_port_cutoff_blink_monitor_unit;
	import cpcbm_pkg::*;

	localparam int unsigned NUM_PORTS      = 3;
	localparam int unsigned RX_HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_LIMIT    = 20000;
	localparam logic [1:0]  REQ_UNUSED     = 2'd3;
	localparam logic [1:0]  PORT_NONE      = 2'd3;

	typedef enum int unsigned {ADC_LOW, ADC_HIGH, ADC_KNEE, ADC_ANY} adc_regime_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_item;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_item;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int unsigned mismatch_count;
	int unsigned results_pending;
	int unsigned hold_req = 0;
	int unsigned hold_served = 0;
	int unsigned low_ma_now = LOW_MA_RST;
	adc_regime_t port_regime [3];

	charge_port_cutoff_blink_monitor_unit #(
		.NUM_PORTS(NUM_PORTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	cpcbm_checker #(
		.NUM_PORTS(NUM_PORTS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_count),
		.results_pending(results_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#15ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// Receiver: random ready duty per span, plus long hold-offs on request
	initial begin
		int unsigned mode;
		int unsigned span;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(8, 64);
			repeat (span) begin
				@(posedge clk);
				if (hold_served < hold_req) begin
					out_ready <= 1'b0;
					repeat (RX_HOLD_CYCLES) @(posedge clk);
					hold_served++;
				end else begin
					out_ready <= ($urandom_range(0, 3) >= mode);
				end
			end
		end
	end

	function automatic in_item_t mk_item(input logic [1:0] req, input int unsigned a0,
		input int unsigned a1, input int unsigned a2, input logic [1:0] port);
		in_item_t it;
		it.req_type = req;
		it.adc_port0 = ADC_W'(a0);
		it.adc_port1 = ADC_W'(a1);
		it.adc_port2 = ADC_W'(a2);
		it.press_port = port;
		return it;
	endfunction

	function automatic logic [ADC_W-1:0] pick_adc(input adc_regime_t regime);
		int unsigned knee_adc;
		int unsigned v;
		// ADC code where the scaled current crosses the low threshold
		knee_adc = (low_ma_now * 2) / 3;
		if (knee_adc > 1023)
			knee_adc = 1023;
		case (regime)
		ADC_LOW:  return ADC_W'($urandom_range(0, knee_adc));
		ADC_HIGH: return ADC_W'($urandom_range(knee_adc, 1023));
		ADC_KNEE: begin
			case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: begin
				v = knee_adc + $urandom_range(0, 4);
				v = (v >= 2) ? v - 2 : 0;
				if (v > 1023)
					v = 1023;
				return ADC_W'(v);
			end
			endcase
		end
		default: return ADC_W'($urandom_range(0, 1023));
		endcase
	endfunction

	function automatic in_item_t random_item();
		in_item_t    it;
		int unsigned r;
		it.adc_port0 = pick_adc(port_regime[0]);
		it.adc_port1 = pick_adc(port_regime[1]);
		it.adc_port2 = pick_adc(port_regime[2]);
		it.press_port = 2'($urandom_range(0, 3));
		r = $urandom_range(0, 99);
		if (r < 40)
			it.req_type = REQ_SAMPLE;
		else if (r < 80)
			it.req_type = REQ_BLINK;
		else if (r < 94)
			it.req_type = REQ_PRESS;
		else
			it.req_type = REQ_UNUSED;
		return it;
	endfunction

	task automatic new_regimes();
		for (int p = 0; p < 3; p++)
			port_regime[p] = adc_regime_t'($urandom_range(0, 3));
	endtask

	task automatic send_item(input in_item_t it);
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_ready !== 1'b1);
	endtask

	task automatic idle(input int unsigned cycles);
		if (cycles != 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Stop sending and let every outstanding status come back
	task automatic wait_drain();
		int unsigned n;
		n = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input int unsigned low_ma, input int unsigned cutoff,
		input int unsigned divide);
		wait_drain();
		write_reg(CFG_LOW_MA, low_ma);
		write_reg(CFG_CUTOFF, cutoff);
		write_reg(CFG_BLINK_DIV, divide);
		low_ma_now = low_ma;
	endtask

	task automatic run_directed();
		// reset thresholds: 50 mA, 48 ticks, divide 400
		send_item(mk_item(REQ_SAMPLE, 0, 0, 0, 2'd0));
		send_item(mk_item(REQ_SAMPLE, 1023, 1023, 1023, PORT_NONE));
		send_item(mk_item(REQ_SAMPLE, 33, 34, 0, 2'd1));
		send_item(mk_item(REQ_PRESS, 0, 0, 0, 2'd0));
		send_item(mk_item(REQ_PRESS, 1023, 0, 0, 2'd1));
		send_item(mk_item(REQ_PRESS, 0, 1023, 0, 2'd2));
		send_item(mk_item(REQ_PRESS, 0, 0, 1023, PORT_NONE));
		send_item(mk_item(REQ_UNUSED, 1023, 1023, 1023, PORT_NONE));
		send_item(mk_item(REQ_SAMPLE, 1023, 1023, 1023, 2'd0));
		// max threshold, cutoff on first low tick, LED step on every blink tick
		set_config(1534, 0, 1);
		send_item(mk_item(REQ_SAMPLE, 1023, 0, 682, 2'd0));
		repeat (8) send_item(mk_item(REQ_BLINK, 0, 0, 0, 2'd0));
		send_item(mk_item(REQ_PRESS, 0, 0, 0, 2'd1));
		send_item(mk_item(REQ_PRESS, 0, 0, 0, 2'd2));
		send_item(mk_item(REQ_UNUSED, 0, 0, 0, 2'd0));
		send_item(mk_item(REQ_SAMPLE, 0, 0, 0, 2'd0));
		send_item(mk_item(REQ_BLINK, 1023, 1023, 1023, PORT_NONE));
		send_item(mk_item(REQ_PRESS, 0, 0, 0, 2'd0));
		send_item(mk_item(REQ_SAMPLE, 1023, 1023, 1023, 2'd0));
	endtask

	task automatic run_phase(input int unsigned items, input int unsigned low_ma,
		input int unsigned cutoff, input int unsigned divide, input bit squeeze);
		int unsigned sent;
		int unsigned burst;
		int unsigned gap;
		sent = 0;
		set_config(low_ma, cutoff, divide);
		new_regimes();
		if (squeeze) begin
			// receiver holds off while items keep coming, so the block backs up
			hold_req++;
			repeat (30) send_item(random_item());
		end
		while (sent < items) begin
			new_regimes();
			burst = $urandom_range(1, 24);
			repeat (burst) begin
				send_item(random_item());
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			idle(gap);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_phase(150, 50, 3, 1, 1'b0);
		run_phase(150, 0, 1, 2, 1'b0);
		run_phase(150, 1534, 5, 1, 1'b1);
		run_phase(150, 200, 0, 3, 1'b0);
		run_phase(150, 800, 65535, 1023, 1'b0);
		run_phase(150, $urandom_range(0, 1534), $urandom_range(1, 12), 0, 1'b1);
		run_phase(150, 400, 2, 5, 1'b0);
		// mostly low samples against the largest cutoff
		run_phase(150, 1534, 65535, 1, 1'b0);
		run_phase(150, $urandom_range(0, 1534), $urandom_range(1, 30),
			$urandom_range(1, 6), 1'b0);
		wait_drain();

		if (mismatch_count == 0 && results_pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
